// ===== hdl/cltimer_pkg.sv =====
// Shared types and register map constants for the core-local timer block.
package cltimer_pkg;

	// Item kinds carried on the input tuser field.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_WFI   = 2'd3
	} opcode_t;

	// Word addresses (byte offset bits 19:2) of the register window.
	localparam logic [17:0] WORD_MSIP        = 18'h00000;
	localparam logic [17:0] WORD_MTIMECMP_LO = 18'h01000;
	localparam logic [17:0] WORD_MTIMECMP_HI = 18'h01001;
	localparam logic [17:0] WORD_MTIME_LO    = 18'h02ffe;
	localparam logic [17:0] WORD_MTIME_HI    = 18'h02fff;

	// Prescale divisor value after reset.
	localparam logic [15:0] DIVISOR_RESET = 16'd100;

	// One input item.
	typedef struct packed {
		opcode_t     opcode;
		logic [19:0] offset;
		logic [31:0] write_data;
		logic [63:0] supervisor_compare;
		logic        sstc_enable;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [31:0] read_data;
		logic        machine_timer_pending;
		logic        supervisor_timer_pending;
		logic        supervisor_pending_driven;
		logic        software_pending;
		logic        time_advanced;
	} result_t;

endpackage

// ===== hdl/cltimer_core.sv =====
// Timer state, register window and interrupt level logic for one item.
module cltimer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  logic                  step_en,
	input  cltimer_pkg::item_t    item,
	output cltimer_pkg::result_t  res
);
	import cltimer_pkg::*;

	logic [15:0] div_q;
	logic [63:0] time_q;
	logic [15:0] count_q;
	logic [63:0] cmp_q;
	logic        msip_q;

	logic [63:0] nxt_time;
	logic [15:0] nxt_count;
	logic [63:0] nxt_cmp;
	logic        nxt_msip;

	logic [15:0] div_eff;
	logic [16:0] cnt_inc;
	logic        tick_step;
	logic [63:0] time_inc;
	logic        tick_mtp;
	logic        tick_stp;
	logic [17:0] addr_word;
	logic        ge_tm;
	logic        ge_ts;
	logic        lt_ms;
	logic        lt_sm;
	logic        wfi_adv;
	logic [63:0] wfi_target;
	logic [63:0] wr_cmp;
	logic        wr_mtp;
	logic [31:0] rdata;
	logic        mtp;
	logic        stp_raw;
	logic        adv;

	// Prescaler and time increment for tick items; a zero divisor acts as one.
	always_comb begin
		div_eff   = (div_q == 16'd0) ? 16'd1 : div_q;
		cnt_inc   = {1'b0, count_q} + 17'd1;
		tick_step = (cnt_inc >= {1'b0, div_eff});
		time_inc  = time_q + 64'd1;
		tick_mtp  = (time_inc >= cmp_q);
		tick_stp  = (time_inc >= item.supervisor_compare);
	end

	// Compares that run in parallel on the current state.
	always_comb begin
		addr_word  = item.offset[19:2];
		ge_tm      = (time_q >= cmp_q);
		ge_ts      = (time_q >= item.supervisor_compare);
		lt_ms      = (cmp_q < item.supervisor_compare);
		lt_sm      = (item.supervisor_compare < cmp_q);
		wfi_target = lt_ms ? cmp_q : item.supervisor_compare;
		// Time moves only when it is below the nearer compare value.
		wfi_adv    = lt_ms ? !ge_tm : !ge_ts;
	end

	// Compare value after a write, and the machine level against it.
	always_comb begin
		wr_cmp = cmp_q;
		if (addr_word == WORD_MTIMECMP_LO) begin
			wr_cmp[31:0] = item.write_data;
		end else if (addr_word == WORD_MTIMECMP_HI) begin
			wr_cmp[63:32] = item.write_data;
		end
		wr_mtp = (time_q >= wr_cmp);
	end

	// Next state and levels for each item kind.
	always_comb begin
		nxt_time  = time_q;
		nxt_count = count_q;
		nxt_cmp   = cmp_q;
		nxt_msip  = msip_q;
		rdata     = 32'd0;
		mtp       = ge_tm;
		stp_raw   = ge_ts;
		adv       = 1'b0;
		case (item.opcode)
			OP_TICK: begin
				if (tick_step) begin
					nxt_time  = time_inc;
					nxt_count = 16'd0;
					mtp       = tick_mtp;
					stp_raw   = tick_stp;
				end else begin
					nxt_count = cnt_inc[15:0];
				end
			end
			OP_READ: begin
				case (addr_word)
					WORD_MSIP:        rdata = {31'd0, msip_q};
					WORD_MTIMECMP_LO: rdata = cmp_q[31:0];
					WORD_MTIMECMP_HI: rdata = cmp_q[63:32];
					WORD_MTIME_LO:    rdata = time_q[31:0];
					WORD_MTIME_HI:    rdata = time_q[63:32];
					default:          rdata = 32'd0;
				endcase
			end
			OP_WRITE: begin
				if (addr_word == WORD_MSIP) begin
					nxt_msip = item.write_data[0];
				end
				nxt_cmp = wr_cmp;
				mtp     = wr_mtp;
			end
			OP_WFI: begin
				if (wfi_adv) begin
					// New time is the smaller compare; levels follow from their order.
					nxt_time  = wfi_target;
					nxt_count = 16'd0;
					adv       = 1'b1;
					mtp       = !lt_sm;
					stp_raw   = !lt_ms;
				end
			end
			default: begin
				nxt_time = time_q;
			end
		endcase
	end

	// Result of the current item.
	always_comb begin
		res.read_data                 = rdata;
		res.machine_timer_pending     = mtp;
		res.supervisor_timer_pending  = item.sstc_enable & stp_raw;
		res.supervisor_pending_driven = item.sstc_enable;
		res.software_pending          = nxt_msip;
		res.time_advanced             = adv;
	end

	// Divisor register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= DIVISOR_RESET;
		end else if (cfg_wr_en) begin
			div_q <= cfg_wr_data;
		end
	end

	// Timer state is updated as the item moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= 64'd0;
			count_q <= 16'd0;
			cmp_q   <= '1;
			msip_q  <= 1'b0;
		end else if (step_en) begin
			time_q  <= nxt_time;
			count_q <= nxt_count;
			cmp_q   <= nxt_cmp;
			msip_q  <= nxt_msip;
		end
	end

endmodule

// ===== hdl/core_local_timer_interruptor_core.sv =====
// Top level: input register, timer core and result register on stream ports.
// An accepted item waits in the input register; its result is valid once it
// moves to the result register. One item per cycle is taken while the result
// port is not stalled; the timer core updates its state on that move.
// Reset clears time, prescale count and msip, sets mtimecmp to all ones and
// the prescale divisor to 100, and empties both registers.
module core_local_timer_interruptor_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// offset[19:0], write_data[51:20], supervisor_compare[115:52],
	// sstc_enable[116], zero fill [119:117]
	input  logic [119:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_data[31:0], machine_timer_pending[32], supervisor_timer_pending[33],
	// supervisor_pending_driven[34], software_pending[35], time_advanced[36],
	// zero fill [39:37]
	output logic [39:0]  m_axis_tdata
);
	import cltimer_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;
	result_t res_q;
	logic    m_valid_q;

	// Unpack the input item.
	always_comb begin
		in_item.opcode             = opcode_t'(s_axis_tuser);
		in_item.offset             = s_axis_tdata[19:0];
		in_item.write_data         = s_axis_tdata[51:20];
		in_item.supervisor_compare = s_axis_tdata[115:52];
		in_item.sstc_enable        = s_axis_tdata[116];
	end

	// The held item moves on when the result register is free or drains.
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= in_item;
		end
	end

	cltimer_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (advance),
		.item        (item_s1),
		.res         (res)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'd0, res_q.time_advanced, res_q.software_pending,
		res_q.supervisor_pending_driven, res_q.supervisor_timer_pending,
		res_q.machine_timer_pending, res_q.read_data};

endmodule

// ===== hdl/cltimer_chk.sv =====
// Port-level checks on the timer results, bound to the top level.
module cltimer_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// A stalled item holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// The supervisor level is only set while it is driven.
	a_stip_driven: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[34])
		else $error("supervisor pending without sstc");

	// A time advance is never a read, so the read word is zero.
	a_adv_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[36] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("read data on a time advance item");

	// After an advance time sits on one of the compares, so a level is due.
	a_adv_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[36] && m_axis_tdata[34]
		|-> m_axis_tdata[32] || m_axis_tdata[33])
		else $error("time advance left no timer pending");

endmodule

bind core_local_timer_interruptor_core cltimer_chk u_cltimer_chk (.*);
